### rtl/core/sclg_pkg.sv
// ----------------------------------------------------------------------------
// sclg_pkg: shared types and constants for the script-class language guess
// Code-point class ranges, register indexes and language codes.
// ----------------------------------------------------------------------------
package sclg_pkg;

    localparam int unsigned CP_WIDTH    = 21;
    localparam int unsigned LANG_WIDTH  = 3;
    localparam int unsigned TOTAL_WIDTH = 16;
    localparam int unsigned RATIO_WIDTH = 4;
    localparam int unsigned BYTES_WIDTH = 3;
    localparam int unsigned CFG_WIDTH   = 4;
    localparam int unsigned IDX_WIDTH   = 2;

    typedef logic [CP_WIDTH-1:0]    cp_t;
    typedef logic [TOTAL_WIDTH-1:0] total_t;
    typedef logic [RATIO_WIDTH-1:0] ratio_t;
    typedef logic [BYTES_WIDTH-1:0] bytes_t;
    typedef logic [CFG_WIDTH-1:0]   cfg_data_t;
    typedef logic [IDX_WIDTH-1:0]   cfg_idx_t;

    typedef enum logic [LANG_WIDTH-1:0] {
        GUESS_UNKNOWN  = 3'd0,
        GUESS_JAPANESE = 3'd1,
        GUESS_CHINESE  = 3'd2,
        GUESS_ENGLISH  = 3'd3,
        GUESS_KOREAN   = 3'd4,
        GUESS_QUENYA   = 3'd5
    } lang_t;

    localparam cfg_idx_t REG_ENGLISH_RATIO = 2'd0;
    localparam cfg_idx_t REG_QUENYA_RATIO  = 2'd1;
    localparam cfg_idx_t REG_MIN_BYTES     = 2'd2;

    localparam ratio_t RST_ENGLISH_RATIO = 4'd7;
    localparam ratio_t RST_QUENYA_RATIO  = 4'd5;
    localparam bytes_t RST_MIN_BYTES     = 3'd2;
    localparam bytes_t BYTES_MAX         = 3'd7;

    // Kana: hiragana, katakana, katakana phonetic extensions
    localparam cp_t HIRA_LO = 21'h03040;
    localparam cp_t HIRA_HI = 21'h0309F;
    localparam cp_t KATA_LO = 21'h030A0;
    localparam cp_t KATA_HI = 21'h030FF;
    localparam cp_t KEXT_LO = 21'h031F0;
    localparam cp_t KEXT_HI = 21'h031FF;

    // Kanji: unified, extension A, extension B, compatibility
    localparam cp_t CJK_LO  = 21'h04E00;
    localparam cp_t CJK_HI  = 21'h09FFF;
    localparam cp_t CJKA_LO = 21'h03400;
    localparam cp_t CJKA_HI = 21'h04DBF;
    localparam cp_t CJKB_LO = 21'h20000;
    localparam cp_t CJKB_HI = 21'h2A6DF;
    localparam cp_t CJKC_LO = 21'h0F900;
    localparam cp_t CJKC_HI = 21'h0FAFF;

    // Latin letters
    localparam cp_t UPPER_LO = 21'h00041;
    localparam cp_t UPPER_HI = 21'h0005A;
    localparam cp_t LOWER_LO = 21'h00061;
    localparam cp_t LOWER_HI = 21'h0007A;

    // Hangul syllables and jamo
    localparam cp_t HSYL_LO  = 21'h0AC00;
    localparam cp_t HSYL_HI  = 21'h0D7AF;
    localparam cp_t JAMO_LO  = 21'h01100;
    localparam cp_t JAMO_HI  = 21'h011FF;

    // Accented specials
    localparam cp_t ACC_A_ACUTE = 21'h000E1;
    localparam cp_t ACC_E_ACUTE = 21'h000E9;
    localparam cp_t ACC_E_DIAER = 21'h000EB;
    localparam cp_t ACC_I_ACUTE = 21'h000ED;
    localparam cp_t ACC_N_TILDE = 21'h000F1;
    localparam cp_t ACC_O_ACUTE = 21'h000F3;
    localparam cp_t ACC_U_ACUTE = 21'h000FA;
    localparam cp_t ACC_THORN   = 21'h000FE;

    // Place-name kanji
    localparam cp_t PLACE_TO    = 21'h090FD;
    localparam cp_t PLACE_DO    = 21'h09053;
    localparam cp_t PLACE_FU    = 21'h05E9C;
    localparam cp_t PLACE_KEN   = 21'h0770C;
    localparam cp_t PLACE_SHI   = 21'h05E02;
    localparam cp_t PLACE_KU    = 21'h0533A;
    localparam cp_t PLACE_CHO   = 21'h0753A;
    localparam cp_t PLACE_MURA  = 21'h06751;

    // UTF-8 length boundaries
    localparam cp_t UTF8_2B = 21'h00080;
    localparam cp_t UTF8_3B = 21'h00800;
    localparam cp_t UTF8_4B = 21'h10000;

endpackage

### rtl/core/script_class_language_guess_core.sv
// ----------------------------------------------------------------------------
// script_class_language_guess_core: language guess from script classes
// Classifies a stream of code points and gives one language code per text.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready): one beat per code point, s_last_char
//   marks the final character of a text. Output channel (m_valid/m_ready):
//   one beat per text carrying the language code and the character count.
//   Configuration: cfg_wr_en writes cfg_wdata into the register chosen by
//   cfg_index (0 English ratio, 1 Quenya ratio, 2 minimum bytes) at once;
//   write only while the block is idle. Other indexes are ignored.
// Timing:
//   A beat is captured in an input register, then classified and folded into the
//   running counts as it leaves that register; a last beat loads the result
//   register at the edge it leaves, which raises m_valid.
//   Throughput is one code point per cycle while no last beat waits on a held
//   result; the single classify/decide stage between the input and result registers sets that figure.
// Stall:
//   While a result waits on m_ready the block keeps taking non-last beats;
//   a last beat holds in the input register until the result slot frees.
// Reset:
//   aresetn clears the counts, flags and both valid bits and restores the
//   configuration registers to 7, 5 and 2. No clearing pass is needed.
// ----------------------------------------------------------------------------
module script_class_language_guess_core #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  sclg_pkg::cfg_idx_t    cfg_index,
    input  sclg_pkg::cfg_data_t   cfg_wdata,
    // input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sclg_pkg::cp_t         s_code_point,
    input  logic                  s_last_char,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output sclg_pkg::lang_t       m_language,
    output sclg_pkg::total_t      m_char_total
);
    import sclg_pkg::*;

    localparam int unsigned PW = COUNT_WIDTH + RATIO_WIDTH;   // ratio product width
    localparam int unsigned EW = COUNT_WIDTH + TOTAL_WIDTH;   // total clamp width

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [PW-1:0]          prod_t;
    typedef logic [EW-1:0]          ext_t;

    // configuration registers
    ratio_t eng_ratio_reg;
    ratio_t quenya_ratio_reg;
    bytes_t min_bytes_reg;

    // input register
    logic   in_valid_reg;
    cp_t    cp_reg;
    logic   last_reg;

    // running text state
    logic   kana_reg, kanji_reg, hangul_reg, accent_reg, place_reg;
    count_t latin_reg, count_reg;
    bytes_t bytes_reg;

    // result register
    logic   out_valid_reg;
    lang_t  lang_reg;
    total_t total_reg;

    // per-character classes
    logic   cls_kana, cls_kanji, cls_latin, cls_hangul, cls_accent, cls_place;
    logic [2:0] cp_bytes;
    logic [3:0] bytes_sum;

    logic   kana_next, kanji_next, hangul_next, accent_next, place_next;
    count_t latin_next, count_next;
    bytes_t bytes_next;

    prod_t  latin_x10, quenya_bound, english_bound;
    ext_t   count_ext;
    lang_t  lang_next;
    total_t total_next;

    logic   advance;

    // Advance the input register whenever a non-last beat is present, or a
    // last beat has a free result slot.
    assign advance = in_valid_reg && (!last_reg || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign m_valid      = out_valid_reg;
    assign m_language   = lang_reg;
    assign m_char_total = total_reg;

    // classification of the held code point
    always_comb begin
        cls_kana   = (cp_reg >= HIRA_LO && cp_reg <= HIRA_HI) ||
                     (cp_reg >= KATA_LO && cp_reg <= KATA_HI) ||
                     (cp_reg >= KEXT_LO && cp_reg <= KEXT_HI);
        cls_kanji  = (cp_reg >= CJK_LO  && cp_reg <= CJK_HI)  ||
                     (cp_reg >= CJKA_LO && cp_reg <= CJKA_HI) ||
                     (cp_reg >= CJKB_LO && cp_reg <= CJKB_HI) ||
                     (cp_reg >= CJKC_LO && cp_reg <= CJKC_HI);
        cls_latin  = (cp_reg >= UPPER_LO && cp_reg <= UPPER_HI) ||
                     (cp_reg >= LOWER_LO && cp_reg <= LOWER_HI);
        cls_hangul = (cp_reg >= HSYL_LO && cp_reg <= HSYL_HI) ||
                     (cp_reg >= JAMO_LO && cp_reg <= JAMO_HI);
        cls_accent = cp_reg inside {ACC_A_ACUTE, ACC_E_ACUTE, ACC_E_DIAER, ACC_I_ACUTE,
                                    ACC_N_TILDE, ACC_O_ACUTE, ACC_U_ACUTE, ACC_THORN};
        cls_place  = cp_reg inside {PLACE_TO, PLACE_DO, PLACE_FU, PLACE_KEN,
                                    PLACE_SHI, PLACE_KU, PLACE_CHO, PLACE_MURA};

        if (cp_reg < UTF8_2B) begin
            cp_bytes = 3'd1;
        end else if (cp_reg < UTF8_3B) begin
            cp_bytes = 3'd2;
        end else if (cp_reg < UTF8_4B) begin
            cp_bytes = 3'd3;
        end else begin
            cp_bytes = 3'd4;
        end
    end

    // state update: classes are exclusive in priority order kana, kanji,
    // Latin, Hangul; accent and place flags are independent
    always_comb begin
        kana_next   = kana_reg   | cls_kana;
        kanji_next  = kanji_reg  | (!cls_kana && cls_kanji);
        hangul_next = hangul_reg | (!cls_kana && !cls_kanji && !cls_latin && cls_hangul);
        accent_next = accent_reg | cls_accent;
        place_next  = place_reg  | cls_place;

        latin_next = latin_reg;
        if (!cls_kana && !cls_kanji && cls_latin && latin_reg != '1) begin
            latin_next = latin_reg + count_t'(1);
        end
        count_next = (count_reg != '1) ? count_reg + count_t'(1) : count_reg;

        bytes_sum  = {1'b0, bytes_reg} + {1'b0, cp_bytes};
        bytes_next = (bytes_sum > {1'b0, BYTES_MAX}) ? BYTES_MAX : bytes_sum[2:0];
    end

    // decision on the updated state
    always_comb begin
        latin_x10     = (prod_t'(latin_next) << 3) + (prod_t'(latin_next) << 1);
        quenya_bound  = prod_t'(count_next) * prod_t'(quenya_ratio_reg);
        english_bound = prod_t'(count_next) * prod_t'(eng_ratio_reg);

        if (bytes_next < min_bytes_reg) begin
            lang_next = GUESS_UNKNOWN;
        end else if (kana_next) begin
            lang_next = GUESS_JAPANESE;
        end else if (accent_next && latin_x10 > quenya_bound) begin
            lang_next = GUESS_QUENYA;
        end else if (latin_x10 > english_bound) begin
            lang_next = GUESS_ENGLISH;
        end else if (hangul_next) begin
            lang_next = GUESS_KOREAN;
        end else if (kanji_next) begin
            lang_next = place_next ? GUESS_JAPANESE : GUESS_CHINESE;
        end else begin
            lang_next = GUESS_UNKNOWN;
        end

        // clamp the count to the 16-bit total field
        count_ext  = ext_t'(count_next);
        total_next = (count_ext > ext_t'({TOTAL_WIDTH{1'b1}})) ?
                     {TOTAL_WIDTH{1'b1}} : count_ext[TOTAL_WIDTH-1:0];
    end

    // control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eng_ratio_reg    <= RST_ENGLISH_RATIO;
            quenya_ratio_reg <= RST_QUENYA_RATIO;
            min_bytes_reg    <= RST_MIN_BYTES;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            kana_reg         <= 1'b0;
            kanji_reg        <= 1'b0;
            hangul_reg       <= 1'b0;
            accent_reg       <= 1'b0;
            place_reg        <= 1'b0;
            latin_reg        <= '0;
            count_reg        <= '0;
            bytes_reg        <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_ENGLISH_RATIO: eng_ratio_reg    <= cfg_wdata;
                    REG_QUENYA_RATIO:  quenya_ratio_reg <= cfg_wdata;
                    REG_MIN_BYTES:     min_bytes_reg    <= cfg_wdata[BYTES_WIDTH-1:0];
                    default: ;
                endcase
            end

            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            // drop the result once taken, load a new one on a last beat
            if (advance && last_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end

            if (advance) begin
                if (last_reg) begin
                    kana_reg   <= 1'b0;
                    kanji_reg  <= 1'b0;
                    hangul_reg <= 1'b0;
                    accent_reg <= 1'b0;
                    place_reg  <= 1'b0;
                    latin_reg  <= '0;
                    count_reg  <= '0;
                    bytes_reg  <= '0;
                end else begin
                    kana_reg   <= kana_next;
                    kanji_reg  <= kanji_next;
                    hangul_reg <= hangul_next;
                    accent_reg <= accent_next;
                    place_reg  <= place_next;
                    latin_reg  <= latin_next;
                    count_reg  <= count_next;
                    bytes_reg  <= bytes_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cp_reg   <= s_code_point;
            last_reg <= s_last_char;
        end
        if (advance && last_reg) begin
            lang_reg  <= lang_next;
            total_reg <= total_next;
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && last_reg) |=> m_valid)
        else $error("last beat processed without a result");

    a_last_clears_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && last_reg) |=> (count_reg == '0 && bytes_reg == '0 && !kana_reg))
        else $error("text state not cleared after last beat");

    a_result_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_char_total != '0))
        else $error("result with zero characters");

    a_count_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0) |-> (bytes_reg != '0))
        else $error("characters counted without bytes");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && last_reg && out_valid_reg))
        else $error("input stalled without a pending last beat");

endmodule
